// File: hdl/lmfe_pkg.sv
`timescale 1ns / 1ps

package lmfe_pkg;

   localparam int unsigned MAX_DATA_BYTES = 8;
   localparam int unsigned MAX_RESULTS    = 3;

   localparam logic [7:0] SYNC_BYTE      = 8'h55;
   localparam logic [5:0] ID_LIMIT       = 6'h3E;
   localparam logic [5:0] ID_CLASSIC_MIN = 6'h3C;
   localparam logic [7:0] SUM_GOOD       = 8'hFF;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_DATA    = 2'd1,
      CMD_RX_ERR  = 2'd2,
      CMD_TIMEOUT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_PARAM   = 3'd1,
      ST_RANGE   = 3'd2,
      ST_IO      = 3'd3,
      ST_TIMEOUT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PUB  = 2'd1,
      PH_SUB  = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_BYTE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] lin_id;
      logic       subscribe;
      logic       enhanced;
      logic       corrupt_checksum;
      logic [3:0] frame_length;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] bus_byte;
      logic [2:0] status;
      logic       last;
   } result_type;

   // results in delivery order: entry 0 goes out first
   typedef struct packed {
      logic [1:0]                         count;
      result_type [MAX_RESULTS-1:0]       res;
   } result_set_type;

   function automatic logic [7:0] make_pid(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

   // end-around-carry add; a second carry cannot occur
   function automatic logic [7:0] eac_add(input logic [7:0] s, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, s} + {1'b0, b};
      return t[7:0] + {7'd0, t[8]};
   endfunction

   function automatic result_type byte_res(input logic [7:0] b, input logic last);
      result_type r;
      r.kind     = KIND_BYTE;
      r.bus_byte = b;
      r.status   = ST_OK;
      r.last     = last;
      return r;
   endfunction

   function automatic result_type status_res(input status_type st);
      result_type r;
      r.kind     = KIND_STATUS;
      r.bus_byte = 8'd0;
      r.status   = st;
      r.last     = 1'b1;
      return r;
   endfunction

endpackage

// File: hdl/lmfe_req_if.sv
`timescale 1ns / 1ps

interface lmfe_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [5:0] lin_id;
   logic       subscribe;
   logic       enhanced;
   logic       corrupt_checksum;
   logic [3:0] frame_length;
   logic [7:0] data_byte;

   modport source (
      output valid, cmd, lin_id, subscribe, enhanced, corrupt_checksum,
             frame_length, data_byte,
      input  ready
   );
   modport sink (
      input  valid, cmd, lin_id, subscribe, enhanced, corrupt_checksum,
             frame_length, data_byte,
      output ready
   );
endinterface

// File: hdl/lmfe_rsp_if.sv
`timescale 1ns / 1ps

interface lmfe_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] bus_byte;
   logic [2:0] status;
   logic       last;

   modport source (
      output valid, kind, bus_byte, status, last,
      input  ready
   );
   modport sink (
      input  valid, kind, bus_byte, status, last,
      output ready
   );
endinterface

// File: hdl/lmfe_frame_ctl.sv
`timescale 1ns / 1ps

// Frame sequencing state and the result set of one transaction.
module lmfe_frame_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  lmfe_pkg::req_item_type  item,
   output lmfe_pkg::result_set_type rset
);

   lmfe_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          left_ff, left_in;
   logic [7:0]          sum_ff, sum_in;
   logic                corrupt_ff, corrupt_in;

   logic [7:0] pid;
   logic [7:0] sum_add;
   logic [3:0] left_dec;
   logic       use_enh;

   always_comb begin
      pid      = lmfe_pkg::make_pid(item.lin_id);
      sum_add  = lmfe_pkg::eac_add(sum_ff, item.data_byte);
      left_dec = (left_ff != 4'd0) ? left_ff - 4'd1 : left_ff;
      use_enh  = item.enhanced && (item.lin_id < lmfe_pkg::ID_CLASSIC_MIN);

      phase_in   = phase_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      corrupt_in = corrupt_ff;
      rset       = '0;

      case (lmfe_pkg::cmd_type'(item.cmd))
         lmfe_pkg::CMD_START: begin
            phase_in   = lmfe_pkg::PH_IDLE;
            left_in    = 4'd0;
            sum_in     = 8'd0;
            corrupt_in = 1'b0;
            if (item.frame_length > 4'(lmfe_pkg::MAX_DATA_BYTES) ||
                (item.subscribe && item.frame_length == 4'd0)) begin
               rset.count  = 2'd1;
               rset.res[0] = lmfe_pkg::status_res(lmfe_pkg::ST_PARAM);
            end else if (item.lin_id >= lmfe_pkg::ID_LIMIT) begin
               rset.count  = 2'd1;
               rset.res[0] = lmfe_pkg::status_res(lmfe_pkg::ST_RANGE);
            end else begin
               rset.res[0] = lmfe_pkg::byte_res(lmfe_pkg::SYNC_BYTE, 1'b0);
               left_in     = item.frame_length;
               if (item.subscribe) begin
                  phase_in    = lmfe_pkg::PH_SUB;
                  sum_in      = use_enh ? pid : 8'd0;
                  rset.count  = 2'd2;
                  rset.res[1] = lmfe_pkg::byte_res(pid, 1'b1);
               end else if (item.frame_length == 4'd0) begin
                  // empty publish: no checksum byte
                  rset.count  = 2'd3;
                  rset.res[1] = lmfe_pkg::byte_res(pid, 1'b0);
                  rset.res[2] = lmfe_pkg::status_res(lmfe_pkg::ST_OK);
               end else begin
                  phase_in    = lmfe_pkg::PH_PUB;
                  sum_in      = use_enh ? pid : 8'd0;
                  corrupt_in  = item.corrupt_checksum;
                  rset.count  = 2'd2;
                  rset.res[1] = lmfe_pkg::byte_res(pid, 1'b1);
               end
            end
         end
         lmfe_pkg::CMD_DATA: begin
            if (phase_ff == lmfe_pkg::PH_PUB) begin
               sum_in  = sum_add;
               left_in = left_dec;
               if (left_dec == 4'd0) begin
                  phase_in    = lmfe_pkg::PH_IDLE;
                  corrupt_in  = 1'b0;
                  rset.count  = 2'd3;
                  rset.res[0] = lmfe_pkg::byte_res(item.data_byte, 1'b0);
                  // corruption undoes the final inversion
                  rset.res[1] = lmfe_pkg::byte_res(
                     corrupt_ff ? sum_add : ~sum_add, 1'b0);
                  rset.res[2] = lmfe_pkg::status_res(lmfe_pkg::ST_OK);
               end else begin
                  rset.count  = 2'd1;
                  rset.res[0] = lmfe_pkg::byte_res(item.data_byte, 1'b1);
               end
            end else if (phase_ff == lmfe_pkg::PH_SUB) begin
               sum_in = sum_add;
               if (left_ff != 4'd0) begin
                  left_in = left_dec;
               end else begin
                  phase_in    = lmfe_pkg::PH_IDLE;
                  rset.count  = 2'd1;
                  rset.res[0] = lmfe_pkg::status_res(lmfe_pkg::status_type'(
                     (sum_add == lmfe_pkg::SUM_GOOD) ? lmfe_pkg::ST_OK : lmfe_pkg::ST_IO));
               end
            end
         end
         lmfe_pkg::CMD_RX_ERR, lmfe_pkg::CMD_TIMEOUT: begin
            if (phase_ff == lmfe_pkg::PH_SUB) begin
               phase_in    = lmfe_pkg::PH_IDLE;
               left_in     = 4'd0;
               rset.count  = 2'd1;
               rset.res[0] = lmfe_pkg::status_res(lmfe_pkg::status_type'(
                  (lmfe_pkg::cmd_type'(item.cmd) == lmfe_pkg::CMD_RX_ERR) ?
                  lmfe_pkg::ST_IO : lmfe_pkg::ST_TIMEOUT));
            end
         end
         default: begin
            rset = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lmfe_pkg::PH_IDLE;
         left_ff    <= 4'd0;
         sum_ff     <= 8'd0;
         corrupt_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         sum_ff     <= sum_in;
         corrupt_ff <= corrupt_in;
      end
   end

endmodule

// File: hdl/lin_master_frame_engine_unit.sv
`timescale 1ns / 1ps

// LIN master frame engine. Each request transaction is evaluated in the cycle it is
// accepted and its results (zero to three) land in a three-entry result register that
// drains one response transaction per cycle while the response side is ready.
// Requests giving at most one result then stream at one per cycle; one giving more
// holds the request side until its results drain through the single response port.
// The next request is taken in the same cycle the last buffered result leaves.
module lin_master_frame_engine_unit (
   input  logic               clock,
   input  logic               reset,
   lmfe_req_if.sink           req_chan,
   lmfe_rsp_if.source         rsp_chan
);

   lmfe_pkg::req_item_type   item;
   lmfe_pkg::result_set_type rset;
   logic                     take;
   logic                     pop;

   lmfe_pkg::result_type [lmfe_pkg::MAX_RESULTS-1:0] res_ff, res_in;
   logic [1:0]                                       count_ff, count_in;

   assign item.cmd              = req_chan.cmd;
   assign item.lin_id           = req_chan.lin_id;
   assign item.subscribe        = req_chan.subscribe;
   assign item.enhanced         = req_chan.enhanced;
   assign item.corrupt_checksum = req_chan.corrupt_checksum;
   assign item.frame_length     = req_chan.frame_length;
   assign item.data_byte        = req_chan.data_byte;

   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_chan.ready);
   assign take           = req_chan.valid && req_chan.ready;

   lmfe_frame_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (item),
      .rset  (rset)
   );

   assign rsp_chan.valid    = (count_ff != 2'd0);
   assign rsp_chan.kind     = res_ff[0].kind;
   assign rsp_chan.bus_byte = res_ff[0].bus_byte;
   assign rsp_chan.status   = res_ff[0].status;
   assign rsp_chan.last     = res_ff[0].last;

   always_comb begin
      res_in   = res_ff;
      count_in = count_ff;
      if (take) begin
         res_in   = rset.res;
         count_in = rset.count;
      end else if (pop) begin
         for (int i = 0; i < lmfe_pkg::MAX_RESULTS - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (count_ff > 2'd1) |-> !req_chan.ready)
      else $error("request taken while several results are pending");

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last) |-> (count_ff == 2'd1))
      else $error("last flag on a result that is not the final buffered one");

   a_byte_ok_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == lmfe_pkg::KIND_BYTE) |->
      (rsp_chan.status == lmfe_pkg::ST_OK))
      else $error("bus byte result carries a nonzero status");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == 2'd0))
      else $error("result register not empty after reset");
`endif

endmodule

// File: sim/lmfe_frame_checker.sv
`timescale 1ns / 1ps

package lmfe_tb_util_pkg;

   // protected id: P1 in bit 7, P0 in bit 6
   function automatic logic [7:0] lin_pid(input logic [5:0] id);
      return {~^(id & 6'b111010), ^(id & 6'b010111), id};
   endfunction

   function automatic logic [7:0] eac_sum(input logic [7:0] s, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, s} + {1'b0, b};
      return t[7:0] + {7'd0, t[8]};
   endfunction

endpackage

module lmfe_frame_checker (
   input  logic   clock,
   input  logic   reset,
   lmfe_req_if    req_mon,
   lmfe_rsp_if    rsp_mon,
   output int     fail_count,
   output int     pending,
   output int     checked
);

   lmfe_pkg::phase_type    frame_phase;
   logic [3:0]             data_left;
   logic [7:0]             run_sum;
   logic                   inject_bad;
   lmfe_pkg::result_type   expected_q[$];
   int                     fails;
   int                     n_checked;

   function automatic void expect_byte(input logic [7:0] b, input logic last);
      lmfe_pkg::result_type r;
      r.kind     = lmfe_pkg::KIND_BYTE;
      r.bus_byte = b;
      r.status   = lmfe_pkg::ST_OK;
      r.last     = last;
      expected_q.push_back(r);
   endfunction

   function automatic void expect_status(input lmfe_pkg::status_type st);
      lmfe_pkg::result_type r;
      r.kind     = lmfe_pkg::KIND_STATUS;
      r.bus_byte = 8'd0;
      r.status   = st;
      r.last     = 1'b1;
      expected_q.push_back(r);
   endfunction

   function automatic void predict_frame_step(input lmfe_pkg::req_item_type t);
      logic [7:0] pid;
      logic [7:0] ck;
      logic       use_enh;
      case (lmfe_pkg::cmd_type'(t.cmd))
         lmfe_pkg::CMD_START: begin
            frame_phase = lmfe_pkg::PH_IDLE;
            data_left   = 4'd0;
            run_sum     = 8'd0;
            inject_bad  = 1'b0;
            if (t.frame_length > lmfe_pkg::MAX_DATA_BYTES ||
                (t.subscribe && t.frame_length == 4'd0)) begin
               expect_status(lmfe_pkg::ST_PARAM);
            end else if (t.lin_id >= lmfe_pkg::ID_LIMIT) begin
               expect_status(lmfe_pkg::ST_RANGE);
            end else begin
               // diagnostic ids always use the classic sum
               use_enh   = t.enhanced && (t.lin_id < lmfe_pkg::ID_CLASSIC_MIN);
               pid       = lmfe_tb_util_pkg::lin_pid(t.lin_id);
               data_left = t.frame_length;
               run_sum   = use_enh ? pid : 8'd0;
               expect_byte(lmfe_pkg::SYNC_BYTE, 1'b0);
               if (t.subscribe) begin
                  frame_phase = lmfe_pkg::PH_SUB;
                  expect_byte(pid, 1'b1);
               end else if (t.frame_length == 4'd0) begin
                  run_sum = 8'd0;
                  expect_byte(pid, 1'b0);
                  expect_status(lmfe_pkg::ST_OK);
               end else begin
                  frame_phase = lmfe_pkg::PH_PUB;
                  inject_bad  = t.corrupt_checksum;
                  expect_byte(pid, 1'b1);
               end
            end
         end
         lmfe_pkg::CMD_DATA: begin
            if (frame_phase == lmfe_pkg::PH_PUB) begin
               run_sum = lmfe_tb_util_pkg::eac_sum(run_sum, t.data_byte);
               if (data_left != 4'd0) data_left = data_left - 4'd1;
               if (data_left == 4'd0) begin
                  ck = ~run_sum;
                  if (inject_bad) ck = ~ck;
                  frame_phase = lmfe_pkg::PH_IDLE;
                  inject_bad  = 1'b0;
                  expect_byte(t.data_byte, 1'b0);
                  expect_byte(ck, 1'b0);
                  expect_status(lmfe_pkg::ST_OK);
               end else begin
                  expect_byte(t.data_byte, 1'b1);
               end
            end else if (frame_phase == lmfe_pkg::PH_SUB) begin
               run_sum = lmfe_tb_util_pkg::eac_sum(run_sum, t.data_byte);
               if (data_left != 4'd0) begin
                  data_left = data_left - 4'd1;
               end else begin
                  // this byte was the slave checksum
                  frame_phase = lmfe_pkg::PH_IDLE;
                  expect_status(lmfe_pkg::status_type'(run_sum == lmfe_pkg::SUM_GOOD ?
                                lmfe_pkg::ST_OK : lmfe_pkg::ST_IO));
               end
            end
         end
         default: begin
            if (frame_phase == lmfe_pkg::PH_SUB) begin
               frame_phase = lmfe_pkg::PH_IDLE;
               data_left   = 4'd0;
               expect_status(lmfe_pkg::status_type'(t.cmd == lmfe_pkg::CMD_RX_ERR ?
                             lmfe_pkg::ST_IO : lmfe_pkg::ST_TIMEOUT));
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         fails++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      lmfe_pkg::result_type   got;
      lmfe_pkg::result_type   want;
      lmfe_pkg::req_item_type req;
      if (reset) begin
         frame_phase = lmfe_pkg::PH_IDLE;
         data_left   = 4'd0;
         run_sum     = 8'd0;
         inject_bad  = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.kind, rsp_mon.bus_byte, rsp_mon.status, rsp_mon.last};
            n_checked++;
            if (expected_q.size() == 0) begin
               fails++;
               $display("%0t ns: result transaction with nothing expected, expected none, got %0h",
                        $time, got);
            end else begin
               want = expected_q.pop_front();
               check_field("kind", {7'd0, want.kind}, {7'd0, got.kind});
               check_field("bus_byte", want.bus_byte, got.bus_byte);
               check_field("status", {5'd0, want.status}, {5'd0, got.status});
               check_field("last", {7'd0, want.last}, {7'd0, got.last});
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req = {req_mon.cmd, req_mon.lin_id, req_mon.subscribe, req_mon.enhanced,
                   req_mon.corrupt_checksum, req_mon.frame_length, req_mon.data_byte};
            predict_frame_step(req);
         end
      end
      pending    <= expected_q.size();
      fail_count <= fails;
      checked    <= n_checked;
   end

endmodule

// File: sim/lin_master_frame_engine_unit_tb.sv
`timescale 1ns / 1ps

module lin_master_frame_engine_unit_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 150;
   localparam int LONG_STALL   = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   fail_count;
   int   pending;
   int   checked;
   int   cycles;
   int   items_sent;
   int   starts;
   bit   tx_calm;
   bit   rx_calm;
   bit   long_stall_req;

   lmfe_req_if req_chan ();
   lmfe_rsp_if rsp_chan ();

   lin_master_frame_engine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lmfe_frame_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic lmfe_pkg::req_item_type frame_req(input lmfe_pkg::cmd_type cmd,
                                                        input logic [5:0] id,
                                                        input logic sub, input logic enh,
                                                        input logic cor,
                                                        input logic [3:0] len,
                                                        input logic [7:0] db);
      lmfe_pkg::req_item_type t;
      t.cmd              = cmd;
      t.lin_id           = id;
      t.subscribe        = sub;
      t.enhanced         = enh;
      t.corrupt_checksum = cor;
      t.frame_length     = len;
      t.data_byte        = db;
      return t;
   endfunction

   function automatic lmfe_pkg::req_item_type noise_item();
      lmfe_pkg::req_item_type t;
      t.cmd              = 2'($urandom_range(0, 3));
      t.lin_id           = 6'($urandom_range(0, 63));
      t.subscribe        = 1'($urandom_range(0, 1));
      t.enhanced         = 1'($urandom_range(0, 1));
      t.corrupt_checksum = 1'($urandom_range(0, 1));
      t.frame_length     = 4'($urandom_range(0, 15));
      t.data_byte        = 8'($urandom_range(0, 255));
      return t;
   endfunction

   task automatic put_item(input lmfe_pkg::req_item_type it);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.cmd              <= it.cmd;
      req_chan.lin_id           <= it.lin_id;
      req_chan.subscribe        <= it.subscribe;
      req_chan.enhanced         <= it.enhanced;
      req_chan.corrupt_checksum <= it.corrupt_checksum;
      req_chan.frame_length     <= it.frame_length;
      req_chan.data_byte        <= it.data_byte;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (it.cmd == lmfe_pkg::CMD_START) starts++;
   endtask

   // stop offering and wait until every predicted result has been seen
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mostly well-formed frame with random content, sometimes aborted part way
   task automatic run_frame();
      lmfe_pkg::req_item_type it;
      logic [7:0]   acc;
      logic [3:0]   len;
      int           n;
      int           cut;
      int           i;
      int           pick;
      it     = noise_item();
      it.cmd = lmfe_pkg::CMD_START;
      pick   = $urandom_range(0, 15);
      if (pick == 0)      it.lin_id = 6'($urandom_range(62, 63));
      else if (pick < 3)  it.lin_id = 6'($urandom_range(60, 61));
      else                it.lin_id = 6'($urandom_range(0, 59));
      len = it.subscribe ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 8));
      it.frame_length = len;
      put_item(it);
      acc = (it.enhanced && it.lin_id < lmfe_pkg::ID_CLASSIC_MIN) ?
            lmfe_tb_util_pkg::lin_pid(it.lin_id) : 8'd0;
      n   = it.subscribe ? len + 1 : len;
      cut = (n > 0 && $urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : -1;
      for (i = 0; i < n; i++) begin
         it = noise_item();
         if (i == cut) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)      it.cmd = lmfe_pkg::CMD_START;
            else if (pick == 1) it.cmd = lmfe_pkg::CMD_RX_ERR;
            else                it.cmd = lmfe_pkg::CMD_TIMEOUT;
            put_item(it);
            return;
         end
         it.cmd = lmfe_pkg::CMD_DATA;
         if (i == len && $urandom_range(0, 3) != 0) it.data_byte = ~acc;
         acc = lmfe_tb_util_pkg::eac_sum(acc, it.data_byte);
         put_item(it);
      end
   endtask

   // response side: random stalls, calm stretches, one long hold-off on request
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            long_stall_req = 1'b0;
         end else begin
            gap = rx_calm ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            do @(posedge clock); while (!rsp_chan.valid);
            if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
         end
      end
   end

   initial begin
      int         target;
      bit         did_stall;
      bit         did_pause;
      logic [7:0] ck;
      req_chan.valid            <= 1'b0;
      req_chan.cmd              <= lmfe_pkg::CMD_START;
      req_chan.lin_id           <= 6'd0;
      req_chan.subscribe        <= 1'b0;
      req_chan.enhanced         <= 1'b0;
      req_chan.corrupt_checksum <= 1'b0;
      req_chan.frame_length     <= 4'd0;
      req_chan.data_byte        <= 8'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // idle-state commands are ignored
      put_item(frame_req(lmfe_pkg::CMD_DATA,    6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'hFF));
      put_item(frame_req(lmfe_pkg::CMD_RX_ERR,  6'h3F, 1'b1, 1'b1, 1'b1, 4'd15, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_TIMEOUT, 6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      // rejects: too long, empty request, length checked before id, id out of range
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h00, 1'b0, 1'b0, 1'b0, 4'd9, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h05, 1'b1, 1'b1, 1'b0, 4'd0, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h3F, 1'b0, 1'b0, 1'b0, 4'd15, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h3E, 1'b0, 1'b1, 1'b0, 4'd1, 8'h00));
      // empty publish on a diagnostic id
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h3C, 1'b0, 1'b1, 1'b0, 4'd0, 8'h00));
      // corrupted checksum, classic forced
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h3D, 1'b0, 1'b1, 1'b1, 4'd2, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'hFF));
      put_item(frame_req(lmfe_pkg::CMD_DATA,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h3B, 1'b0, 1'b1, 1'b0, 4'd1, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'hFF));
      // new start drops a publish in progress; subscribe with good checksum
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h2A, 1'b0, 1'b0, 1'b0, 4'd3, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h12));
      put_item(frame_req(lmfe_pkg::CMD_START, 6'h15, 1'b1, 1'b1, 1'b0, 4'd1, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'hA5));
      ck = ~lmfe_tb_util_pkg::eac_sum(lmfe_tb_util_pkg::lin_pid(6'h15), 8'hA5);
      put_item(frame_req(lmfe_pkg::CMD_DATA,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, ck));
      // receive error and timeout while subscribing, bad slave checksum
      put_item(frame_req(lmfe_pkg::CMD_START,   6'h3C, 1'b1, 1'b1, 1'b0, 4'd8, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,    6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h33));
      put_item(frame_req(lmfe_pkg::CMD_RX_ERR,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_START,   6'h01, 1'b1, 1'b0, 1'b0, 4'd1, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_TIMEOUT, 6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_START,   6'h20, 1'b1, 1'b0, 1'b0, 4'd1, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,    6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,    6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      // error while publishing is ignored
      put_item(frame_req(lmfe_pkg::CMD_START,   6'h07, 1'b0, 1'b0, 1'b1, 4'd1, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_RX_ERR,  6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h00));
      put_item(frame_req(lmfe_pkg::CMD_DATA,    6'h00, 1'b0, 1'b0, 1'b0, 4'd0, 8'h80));
      drain();

      target    = items_sent + RANDOM_ITEMS;
      did_stall = 1'b0;
      did_pause = 1'b0;
      while (items_sent < target) begin
         if ($urandom_range(0, 5) == 0) tx_calm = ($urandom_range(0, 3) == 0);
         if (!did_stall && items_sent > target - 120) begin
            // response side holds off; back-to-back requests fill the block
            did_stall      = 1'b1;
            tx_calm        = 1'b1;
            long_stall_req = 1'b1;
            repeat (4) run_frame();
            tx_calm        = 1'b0;
         end
         if (!did_pause && items_sent > target - 60) begin
            did_pause = 1'b1;
            drain();
         end
         if ($urandom_range(0, 4) == 0) put_item(noise_item());
         else                           run_frame();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d request transactions in %0d frame starts, checked %0d results",
               items_sent, starts, checked);
      $display("Covered publish and subscribe frames, aborts, rejects and long back-pressure");
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
